// File: rtl/acss_pkg.sv
package acss_pkg;

    localparam int MAX_CHAIN   = 16;
    localparam int SAMPLE_BITS = 10;
    localparam int CHAN_W      = 4;
    localparam int POS_W       = 5;
    localparam int TICK_W      = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    // event codes carried in the mode field
    localparam logic [1:0] MODE_START_SINGLE = 2'd0;
    localparam logic [1:0] MODE_START_CHAIN  = 2'd1;
    localparam logic [1:0] MODE_CONV_DONE    = 2'd2;
    localparam logic [1:0] MODE_TICK         = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BUSY     = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_CHANNELS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT   = 2'd3;

    localparam logic [CFG_DATA_W-1:0] CHAIN_CHANNELS_RST  = '0;
    localparam logic [POS_W-1:0]      CHAIN_LENGTH_RST    = 5'd1;
    localparam logic                  RESOLUTION_MODE_RST = 1'b1;
    localparam logic [TICK_W-1:0]     TIMEOUT_LIMIT_RST   = 16'd50000;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_CHAIN  = 2'd2
    } run_kind_t;

    typedef struct packed {
        logic [1:0]             mode;
        logic [CHAN_W-1:0]      channel;
        logic                   timed;
        logic [SAMPLE_BITS-1:0] sample;
    } item_t;

    typedef struct packed {
        logic [1:0]             status;
        logic                   start_request;
        logic [CHAN_W-1:0]      convert_channel;
        logic                   result_valid;
        logic [SAMPLE_BITS-1:0] result_value;
        logic [CHAN_W-1:0]      result_index;
        logic                   last;
        logic                   busy_res;
    } result_t;

endpackage

// File: rtl/adc_channel_scan_sequencer.sv
// Scan sequencer for an analog converter: takes start, conversion-done and tick
// events, one beat per cycle, and answers each with exactly one result beat
// carrying the converter start request, the delivered sample with its chain
// position, the last flag, status and busy. Every event is decided in the
// cycle it is accepted, from the run state registers, so events may follow
// back to back at one per cycle; the answer is registered in the output
// register or the skid register. A two-entry output buffer (output register
// plus skid register) lets the input keep flowing while a result waits, so
// input stall rises only once both entries are full. Configuration writes
// take effect at once and are meant to be made while the block is idle.
module adc_channel_scan_sequencer
    import acss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // event input channel
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    // result output channel
    output logic                  res_valid,
    input  logic                  res_stall,
    output result_t               res,
    // configuration write port
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [CFG_DATA_W-1:0]  chain_channels_reg;
    logic [POS_W-1:0]       chain_length_reg;
    logic                   resolution_mode_reg;
    logic [TICK_W-1:0]      timeout_limit_reg;

    // run state
    logic                   busy_reg, busy_next;
    run_kind_t              run_kind_reg, run_kind_next;
    logic [POS_W-1:0]       chain_pos_reg, chain_pos_next;
    logic [TICK_W-1:0]      wait_ticks_reg, wait_ticks_next;
    logic                   timed_run_reg, timed_run_next;

    // output buffer
    logic                   out_valid_reg, out_valid_next;
    logic                   skid_valid_reg, skid_valid_next;
    result_t                out_reg, out_next;
    result_t                skid_reg, skid_next;

    logic                   item_accept;
    logic                   out_take;
    result_t                result;

    logic [POS_W-1:0]       eff_length;
    logic [TICK_W-1:0]      eff_limit;
    logic [POS_W-1:0]       pos_inc;
    logic [TICK_W-1:0]      ticks_inc;
    logic [CHAN_W-1:0]      list_chan0;
    logic [CHAN_W-1:0]      list_chan_inc;
    logic [SAMPLE_BITS-1:0] shaped;

    // handshake: stall only when the skid entry is taken
    assign item_stall  = skid_valid_reg;
    assign item_accept = item_valid && !skid_valid_reg;
    assign out_take    = out_valid_reg && !res_stall;
    assign res_valid   = out_valid_reg;
    assign res         = out_reg;

    // chain length clamped to 1..MAX_CHAIN, time-out limit of zero acts as one
    always_comb
    begin
        if (chain_length_reg == '0)
            eff_length = POS_W'(1);
        else if (chain_length_reg > POS_W'(MAX_CHAIN))
            eff_length = POS_W'(MAX_CHAIN);
        else
            eff_length = chain_length_reg;
    end

    assign eff_limit = (timeout_limit_reg == '0) ? TICK_W'(1) : timeout_limit_reg;
    assign pos_inc   = chain_pos_reg + POS_W'(1);
    assign ticks_inc = wait_ticks_reg + TICK_W'(1);

    // channel list lookups: entry 0 for a chain start, next entry on each done
    assign list_chan0    = chain_channels_reg[CHAN_W-1:0];
    assign list_chan_inc = chain_channels_reg[{pos_inc[CHAN_W-1:0], 2'b00} +: CHAN_W];

    // eight-bit mode keeps the top 8 bits of the sample
    assign shaped = resolution_mode_reg ? item.sample
                  : SAMPLE_BITS'(item.sample >> (SAMPLE_BITS - 8));

    // event decode: result beat and next run state
    always_comb
    begin
        result          = '0;
        busy_next       = busy_reg;
        run_kind_next   = run_kind_reg;
        chain_pos_next  = chain_pos_reg;
        wait_ticks_next = wait_ticks_reg;
        timed_run_next  = timed_run_reg;

        case (item.mode)
            MODE_START_SINGLE, MODE_START_CHAIN:
            begin
                if (busy_reg)
                begin
                    result.status = STATUS_BUSY;
                end
                else
                begin
                    busy_next            = 1'b1;
                    wait_ticks_next      = '0;
                    chain_pos_next       = '0;
                    result.start_request = 1'b1;
                    if (item.mode == MODE_START_SINGLE)
                    begin
                        run_kind_next          = KIND_SINGLE;
                        timed_run_next         = item.timed;
                        result.convert_channel = item.channel;
                    end
                    else
                    begin
                        run_kind_next          = KIND_CHAIN;
                        timed_run_next         = 1'b0;
                        result.convert_channel = list_chan0;
                    end
                end
            end
            MODE_CONV_DONE:
            begin
                if (busy_reg && run_kind_reg == KIND_SINGLE)
                begin
                    result.result_valid = 1'b1;
                    result.result_value = shaped;
                    result.last         = 1'b1;
                    busy_next           = 1'b0;
                    run_kind_next       = KIND_NONE;
                    chain_pos_next      = '0;
                    wait_ticks_next     = '0;
                    timed_run_next      = 1'b0;
                end
                else if (busy_reg && run_kind_reg == KIND_CHAIN)
                begin
                    result.result_valid = 1'b1;
                    result.result_value = shaped;
                    result.result_index = chain_pos_reg[CHAN_W-1:0];
                    if (pos_inc >= eff_length)
                    begin
                        // end of the chain run
                        result.last     = 1'b1;
                        busy_next       = 1'b0;
                        run_kind_next   = KIND_NONE;
                        chain_pos_next  = '0;
                        wait_ticks_next = '0;
                        timed_run_next  = 1'b0;
                    end
                    else
                    begin
                        chain_pos_next         = pos_inc;
                        result.start_request   = 1'b1;
                        result.convert_channel = list_chan_inc;
                    end
                end
            end
            MODE_TICK:
            begin
                if (busy_reg && run_kind_reg == KIND_SINGLE && timed_run_reg)
                begin
                    wait_ticks_next = ticks_inc;
                    if (ticks_inc >= eff_limit)
                    begin
                        result.status   = STATUS_TIMEOUT;
                        busy_next       = 1'b0;
                        run_kind_next   = KIND_NONE;
                        chain_pos_next  = '0;
                        wait_ticks_next = '0;
                        timed_run_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase

        result.busy_res = busy_next;
    end

    // output register plus skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            // no beat is accepted while the skid entry is full
            if (out_take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_next = item_accept;
            if (item_accept)
                out_next = result;
        end
        else if (item_accept)
        begin
            skid_valid_next = 1'b1;
            skid_next       = result;
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_channels_reg  <= CHAIN_CHANNELS_RST;
            chain_length_reg    <= CHAIN_LENGTH_RST;
            resolution_mode_reg <= RESOLUTION_MODE_RST;
            timeout_limit_reg   <= TIMEOUT_LIMIT_RST;
            busy_reg            <= 1'b0;
            run_kind_reg        <= KIND_NONE;
            chain_pos_reg       <= '0;
            wait_ticks_reg      <= '0;
            timed_run_reg       <= 1'b0;
            out_valid_reg       <= 1'b0;
            skid_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_CHAIN_CHANNELS:  chain_channels_reg  <= cfg_data;
                    REG_CHAIN_LENGTH:    chain_length_reg    <= cfg_data[POS_W-1:0];
                    REG_RESOLUTION_MODE: resolution_mode_reg <= cfg_data[0];
                    REG_TIMEOUT_LIMIT:   timeout_limit_reg   <= cfg_data[TICK_W-1:0];
                    default:             chain_length_reg    <= chain_length_reg;
                endcase
            end
            if (item_accept)
            begin
                busy_reg       <= busy_next;
                run_kind_reg   <= run_kind_next;
                chain_pos_reg  <= chain_pos_next;
                wait_ticks_reg <= wait_ticks_next;
                timed_run_reg  <= timed_run_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef ASSERT_OFF
    // skid entry is only filled behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full with empty output register");

    // idle means the whole run state is cleared
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (run_kind_reg == KIND_NONE && chain_pos_reg == '0
                       && wait_ticks_reg == '0 && !timed_run_reg))
        else $error("run state left behind while idle");

    // a running chain never points past its configured length
    a_chain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && run_kind_reg == KIND_CHAIN) |-> (chain_pos_reg < eff_length))
        else $error("chain position beyond chain length");

    // timed waiting only belongs to a single conversion
    a_timed_single: assert property (@(posedge clk) disable iff (!rst_n)
        timed_run_reg |-> (busy_reg && run_kind_reg == KIND_SINGLE))
        else $error("timed flag set outside a single conversion");
`endif

endmodule
